// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the colour filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define DBCF_ASSERT_NOW(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define DBCF_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ===== rtl/dbcf_pkg.sv =====
// Shared types, constants and helper functions of the colour filter.
package dbcf_pkg;

  localparam int NCOLORS   = 5;
  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 32;
  localparam int COLOR_W   = 3;
  localparam int CONF_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int TRANS_W   = 10;
  localparam int WT_W      = 18;

  localparam logic [CONF_W-1:0] CONF_LO = 16'd6554;
  localparam logic [CONF_W-1:0] CONF_HI = 16'd64881;

  typedef enum logic [COLOR_W-1:0] {
    COLOR_UNKNOWN = 3'd0,
    COLOR_RED     = 3'd1,
    COLOR_YELLOW  = 3'd2,
    COLOR_GREEN   = 3'd3,
    COLOR_BLACK   = 3'd4
  } color_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_GAP   = 3'd0,
    REG_CLEANUP_GAP = 3'd1,
    REG_THRESHOLD   = 3'd2,
    REG_DARK_WINDOW = 3'd3,
    REG_BLINK_HOLD  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PRED,
    ST_WEIGHT,
    ST_SUM,
    ST_DIVGO,
    ST_DIV,
    ST_FIN
  } state_t;

  // Transition matrix in thousandths, indexed [from][to].
  localparam logic [TRANS_W-1:0] TRANS [NCOLORS][NCOLORS] = '{
    '{10'd900, 10'd25,  10'd25,  10'd25,  10'd25},
    '{10'd10,  10'd950, 10'd10,  10'd30,  10'd0},
    '{10'd10,  10'd190, 10'd800, 10'd0,   10'd0},
    '{10'd10,  10'd0,   10'd90,  10'd900, 10'd0},
    '{10'd100, 10'd225, 10'd225, 10'd225, 10'd225}
  };

  function automatic logic gap_exceeds(input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] prev,
                                       input logic [CFG_W-1:0] gap);
    logic [TIME_W-1:0] d;
    d = now - prev;
    return !d[TIME_W-1] && (d > TIME_W'(gap));
  endfunction

  function automatic logic [TIME_W-1:0] abs_gap(input logic [TIME_W-1:0] now,
                                                input logic [TIME_W-1:0] prev);
    logic [TIME_W-1:0] d;
    d = now - prev;
    return d[TIME_W-1] ? (TIME_W'(0) - d) : d;
  endfunction

endpackage

// ===== rtl/dbcf_if.sv =====
// Valid/ready channel interfaces for observation and result words.
interface dbcf_obs_if import dbcf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic [TIME_W-1:0]   time_ms;
  logic [COLOR_W-1:0]  seen_color;
  logic [CONF_W-1:0]   seen_conf;
  modport source(output valid, slot, time_ms, seen_color, seen_conf, input ready);
  modport sink(input valid, slot, time_ms, seen_color, seen_conf, output ready);
endinterface

interface dbcf_res_if import dbcf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COLOR_W-1:0]  out_color;
  logic [CONF_W-1:0]   out_conf;
  logic                blinking;
  modport source(output valid, out_color, out_conf, blinking, input ready);
  modport sink(input valid, out_color, out_conf, blinking, output ready);
endinterface

// ===== rtl/dbcf_ram.sv =====
// Generic single-port-write, registered-read RAM.
module dbcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dbcf_div.sv =====
// Five-lane restoring divider giving round-half-up fractional quotients.
module dbcf_div import dbcf_pkg::*; #(
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 8,
  parameter int Q_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num [NCOLORS],
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [Q_BITS:0]   quo [NCOLORS]
);

  localparam int CW = $clog2(Q_BITS + 1);

  logic [DEN_W-1:0] rem [NCOLORS];
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   rem2 [NCOLORS];
  logic             ge [NCOLORS];

  assign done = busy && (cnt == CW'(Q_BITS));

  always_comb begin
    for (int c = 0; c < NCOLORS; c++) begin
      rem2[c] = {rem[c], 1'b0};
      ge[c]   = rem2[c] >= {1'b0, den_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      cnt   <= '0;
      for (int c = 0; c < NCOLORS; c++) begin
        if (DEN_W'(num[c]) >= den) begin
          quo[c] <= (Q_BITS + 1)'(1);
          rem[c] <= DEN_W'(num[c]) - den;
        end else begin
          quo[c] <= '0;
          rem[c] <= DEN_W'(num[c]);
        end
      end
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      for (int c = 0; c < NCOLORS; c++) begin
        if (done) begin
          quo[c] <= quo[c] + (Q_BITS + 1)'(ge[c]);
        end else begin
          quo[c] <= {quo[c][Q_BITS-1:0], ge[c]};
          rem[c] <= ge[c] ? DEN_W'(rem2[c] - {1'b0, den_r}) : DEN_W'(rem2[c]);
        end
      end
    end
  end

endmodule

// ===== rtl/discrete_bayes_color_filter_top.sv =====
// Top level of the per-slot five-state colour filter.
// A result word is registered after the load, five-step prediction, weighting, sum and bit-serial divide steps.
// One observation at a time: the next is taken only once the last is written back in the final step,
// which waits while an unread result word is still held.
// Synchronous reset restores the configuration registers and the state, marks every slot fresh and empties the output.
`include "assert_macros.svh"
module discrete_bayes_color_filter_top import dbcf_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int PROB_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  dbcf_obs_if.sink             obs,
  dbcf_res_if.source           res
);

  localparam int AW        = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
  localparam int PW        = PROB_BITS + 1;
  localparam int NX_W      = PW + TRANS_W;
  localparam int W_W       = NX_W + WT_W;
  localparam int TOT_W     = W_W + 3;
  localparam int SV_LO     = 1;
  localparam int DARK_LO   = 3;
  localparam int BRIGHT_LO = DARK_LO + TIME_W;
  localparam int SEEN_LO   = BRIGHT_LO + TIME_W;
  localparam int PROBS_LO  = SEEN_LO + TIME_W;
  localparam int ROW_W     = PROBS_LO + NCOLORS * PW;
  localparam int SH        = PROB_BITS > 16 ? PROB_BITS - 16 : 0;
  localparam int LSH       = PROB_BITS < 16 ? 16 - PROB_BITS : 0;
  localparam logic [63:0] ONE = 64'd1 << PROB_BITS;
  localparam logic [PW-1:0] P_UNK  = PW'((6 * ONE + 64'd5) / 64'd10);
  localparam logic [PW-1:0] P_OTH  = PW'((2 * ONE + 64'd10) / 64'd20);
  localparam logic [PW-1:0] P_UNIF = PW'((2 * ONE + 64'd5) / 64'd10);
  localparam logic [PW:0] HALF = SH > 0 ? (PW + 1)'(1) << (SH > 0 ? SH - 1 : 0) : '0;

  state_t state, state_next;

  logic [CFG_W-1:0] reset_gap_ms, cleanup_gap_ms, decide_threshold;
  logic [CFG_W-1:0] blink_dark_window_ms, blink_hold_ms;

  logic [NUM_SLOTS-1:0] used;
  logic [AW-1:0]        slot_idx, cur_slot;
  logic [TIME_W-1:0]    cur_t, bright, dark;
  logic [COLOR_W-1:0]   cur_obs;
  logic [CONF_W-1:0]    cur_conf, conf_clamped;
  logic [1:0]           sv;
  logic                 blink;
  logic [PW-1:0]        probs [NCOLORS];
  logic [2:0]           pcnt;
  logic [NX_W-1:0]      nx [NCOLORS];
  logic [W_W-1:0]       w [NCOLORS];
  logic [WT_W-1:0]      wt [NCOLORS];
  logic [TOT_W-1:0]     total, total_sum;

  logic                 accept, ram_we, ram_re, div_start, div_done;
  logic [ROW_W-1:0]     rdata, wdata;
  logic [PW-1:0]        quo [NCOLORS];

  logic [TIME_W-1:0]    rd_seen;
  logic                 fresh, reload;

  logic [PW-1:0]        newp [NCOLORS];
  logic [PW-1:0]        best_p, cur_p;
  logic [COLOR_W-1:0]   best, cur;
  logic [PW+16:0]       scaled;
  logic [CONF_W-1:0]    q16;
  logic [TIME_W-1:0]    bright_n, dark_n;
  logic [1:0]           sv_n;
  logic                 blink_n;
  logic                 res_valid;
  logic [COLOR_W-1:0]   res_color;
  logic [CONF_W-1:0]    res_conf;
  logic                 res_blink;

  assign accept    = obs.valid && obs.ready;
  assign obs.ready = (state == ST_IDLE) && !rst;
  assign ram_re    = accept;

  assign res.valid     = res_valid;
  assign res.out_color = res_color;
  assign res.out_conf  = res_conf;
  assign res.blinking  = res_blink;

  always_comb begin
    slot_idx = '0;
    for (int i = 0; i < (1 << SLOT_W); i++) begin
      if (obs.slot == SLOT_W'(i)) begin
        slot_idx = AW'(i % NUM_SLOTS);
      end
    end
  end

  always_comb begin
    if (obs.seen_conf < CONF_LO) begin
      conf_clamped = CONF_LO;
    end else if (obs.seen_conf > CONF_HI) begin
      conf_clamped = CONF_HI;
    end else begin
      conf_clamped = obs.seen_conf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_gap_ms         <= 16'd2000;
      cleanup_gap_ms       <= 16'd5000;
      decide_threshold     <= 16'd22938;
      blink_dark_window_ms <= 16'd500;
      blink_hold_ms        <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_GAP:   reset_gap_ms         <= cfg_data;
        REG_CLEANUP_GAP: cleanup_gap_ms       <= cfg_data;
        REG_THRESHOLD:   decide_threshold     <= cfg_data;
        REG_DARK_WINDOW: blink_dark_window_ms <= cfg_data;
        REG_BLINK_HOLD:  blink_hold_ms        <= cfg_data;
        default: ;
      endcase
    end
  end

  dbcf_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_slot),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (slot_idx),
    .rdata (rdata)
  );

  dbcf_div #(
    .NUM_W  (W_W),
    .DEN_W  (TOT_W),
    .Q_BITS (PROB_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (w),
    .den   (total),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_PRED;
      ST_PRED:   if (pcnt == 3'(NCOLORS - 1)) state_next = ST_WEIGHT;
      ST_WEIGHT: state_next = ST_SUM;
      ST_SUM:    state_next = ST_DIVGO;
      ST_DIVGO: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV:    if (div_done) state_next = ST_FIN;
      ST_FIN: begin
        if (!res_valid || res.ready) begin
          ram_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  assign rd_seen = rdata[SEEN_LO +: TIME_W];
  assign fresh   = !used[cur_slot] || gap_exceeds(cur_t, rd_seen, cleanup_gap_ms);
  assign reload  = fresh || gap_exceeds(cur_t, rd_seen, reset_gap_ms);

  always_comb begin
    for (int c = 0; c < NCOLORS; c++) begin
      if (cur_obs >= 3'd1 && cur_obs <= 3'd4) begin
        wt[c] = (cur_obs == COLOR_W'(c)) ? WT_W'({cur_conf, 2'b00})
                                         : WT_W'(18'd65536 - WT_W'(cur_conf));
      end else begin
        wt[c] = WT_W'(1);
      end
    end
    total_sum = '0;
    for (int c = 0; c < NCOLORS; c++) begin
      total_sum = total_sum + TOT_W'(w[c]);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cur_slot <= slot_idx;
          cur_t    <= obs.time_ms;
          cur_obs  <= obs.seen_color;
          cur_conf <= conf_clamped;
        end
      end
      ST_LOAD: begin
        for (int c = 0; c < NCOLORS; c++) begin
          if (reload) begin
            probs[c] <= (c == 0) ? P_UNK : P_OTH;
          end else begin
            probs[c] <= rdata[PROBS_LO + c * PW +: PW];
          end
          nx[c] <= '0;
        end
        bright <= rdata[BRIGHT_LO +: TIME_W];
        dark   <= rdata[DARK_LO +: TIME_W];
        sv     <= fresh ? 2'b00 : rdata[SV_LO +: 2];
        blink  <= fresh ? 1'b0 : rdata[0];
        pcnt   <= '0;
      end
      ST_PRED: begin
        for (int c = 0; c < NCOLORS; c++) begin
          nx[c] <= nx[c] + NX_W'(probs[pcnt]) * NX_W'(TRANS[pcnt][c]);
        end
        pcnt <= pcnt + 3'd1;
      end
      ST_WEIGHT: begin
        for (int c = 0; c < NCOLORS; c++) begin
          w[c] <= W_W'(nx[c]) * W_W'(wt[c]);
        end
      end
      ST_SUM: total <= total_sum;
      default: ;
    endcase
  end

  always_comb begin
    for (int c = 0; c < NCOLORS; c++) begin
      newp[c] = (total == '0) ? P_UNIF : quo[c];
    end
    best   = COLOR_UNKNOWN;
    best_p = newp[0];
    for (int c = 1; c < NCOLORS; c++) begin
      if (newp[c] > best_p) begin
        best   = COLOR_W'(c);
        best_p = newp[c];
      end
    end
    if ((PW + 16)'({best_p, 16'h0000}) < (PW + 16)'({decide_threshold, PROB_BITS'(0)})) begin
      cur   = COLOR_UNKNOWN;
      cur_p = newp[0];
    end else begin
      cur   = best;
      cur_p = best_p;
    end
    scaled = ((PW + 17)'({1'b0, cur_p} + HALF) >> SH) << LSH;
    q16    = (|scaled[PW+16:16]) ? 16'hFFFF : scaled[15:0];

    bright_n = bright;
    dark_n   = dark;
    sv_n     = sv;
    if (cur == COLOR_GREEN) begin
      bright_n = cur_t;
      sv_n[0]  = 1'b1;
    end else if (cur == COLOR_BLACK || cur == COLOR_UNKNOWN) begin
      dark_n  = cur_t;
      sv_n[1] = 1'b1;
    end
    if (cur == COLOR_GREEN && sv_n[1] &&
        abs_gap(cur_t, dark_n) < TIME_W'(blink_dark_window_ms)) begin
      blink_n = 1'b1;
    end else if (!sv_n[0] || gap_exceeds(cur_t, bright_n, blink_hold_ms)) begin
      blink_n = 1'b0;
    end else begin
      blink_n = blink;
    end

    wdata = '0;
    for (int c = 0; c < NCOLORS; c++) begin
      wdata[PROBS_LO + c * PW +: PW] = newp[c];
    end
    wdata[SEEN_LO +: TIME_W]   = cur_t;
    wdata[BRIGHT_LO +: TIME_W] = bright_n;
    wdata[DARK_LO +: TIME_W]   = dark_n;
    wdata[SV_LO +: 2]          = sv_n;
    wdata[0]                   = blink_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (ram_we) begin
        used[cur_slot] <= 1'b1;
        res_valid      <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      res_color <= cur;
      res_conf  <= q16;
      res_blink <= blink_n;
    end
  end

  `DBCF_ASSERT_NEXT(a_single_item, accept, !obs.ready, "observation word taken while busy")
  `DBCF_ASSERT_NOW(a_wb_fin, ram_we, state == ST_FIN && (!res_valid || res.ready), "slot written back outside the final step")
  `DBCF_ASSERT_NOW(a_div_state, div_done, state == ST_DIV, "divider finished outside its wait state")

endmodule

// ===== sim/tb_discrete_bayes_color_filter_top.sv =====
// Testbench for the colour filter: directed and random observations checked against a predictor.
module tb_discrete_bayes_color_filter_top;
  import dbcf_pkg::*;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [CONF_W-1:0]  conf;
    logic               blink;
  } verdict_t;

  class colour_scoreboard;
    verdict_t pending[$];
    int errors;
    logic [15:0] reset_gap, cleanup_gap, threshold, dark_window, blink_hold;
    logic [16:0] probs [16][NCOLORS];
    logic [31:0] seen_ms [16];
    logic [31:0] bright_ms [16];
    logic [31:0] dark_ms [16];
    logic [1:0]  stamps [16];
    logic        blink [16];
    logic        used [16];

    function new();
      reset_gap = 2000;
      cleanup_gap = 5000;
      threshold = 22938;
      dark_window = 500;
      blink_hold = 1000;
      errors = 0;
      for (int s = 0; s < 16; s++) begin
        load_prior(s);
        seen_ms[s] = 0;
        bright_ms[s] = 0;
        dark_ms[s] = 0;
        stamps[s] = 0;
        blink[s] = 0;
        used[s] = 0;
      end
    endfunction

    function void set_reg(cfg_reg_t idx, logic [15:0] v);
      case (idx)
        REG_RESET_GAP:   reset_gap = v;
        REG_CLEANUP_GAP: cleanup_gap = v;
        REG_THRESHOLD:   threshold = v;
        REG_DARK_WINDOW: dark_window = v;
        REG_BLINK_HOLD:  blink_hold = v;
        default: ;
      endcase
    endfunction

    function logic [63:0] scaled_quotient(logic [63:0] num, logic [63:0] den);
      logic [63:0] q, r;
      if (den == 0) return 0;
      q = num / den;
      r = num % den;
      for (int i = 0; i < 16; i++) begin
        q = q << 1;
        r = r << 1;
        if (r >= den) begin
          r = r - den;
          q[0] = 1'b1;
        end
      end
      r = r << 1;
      if (r >= den) q = q + 1;
      return q;
    endfunction

    function void load_prior(int s);
      probs[s][0] = 17'(scaled_quotient(3, 5));
      for (int c = 1; c < NCOLORS; c++) probs[s][c] = 17'(scaled_quotient(1, 10));
    endfunction

    function bit later_by(logic [31:0] now, logic [31:0] prev, logic [15:0] gap);
      logic [31:0] d;
      d = now - prev;
      return !d[31] && d > {16'd0, gap};
    endfunction

    function void note_observation(logic [3:0] s, logic [31:0] t, logic [2:0] obs,
                                   logic [15:0] conf_in);
      logic [63:0] nx, w[NCOLORS], total, wt;
      logic [31:0] cf, d;
      int best;
      logic [2:0] cur;
      verdict_t v;
      if (!used[s] || later_by(t, seen_ms[s], cleanup_gap)) begin
        load_prior(s);
        stamps[s] = 0;
        blink[s] = 0;
      end else if (later_by(t, seen_ms[s], reset_gap)) begin
        load_prior(s);
      end
      cf = {16'd0, conf_in};
      if (cf < CONF_LO) cf = {16'd0, CONF_LO};
      if (cf > CONF_HI) cf = {16'd0, CONF_HI};
      total = 0;
      for (int c = 0; c < NCOLORS; c++) begin
        nx = 0;
        for (int p = 0; p < NCOLORS; p++) nx += 64'(probs[s][p]) * 64'(TRANS[p][c]);
        if (obs >= 1 && obs <= 4) wt = (c == obs) ? 4 * 64'(cf) : 65536 - 64'(cf);
        else wt = 1;
        w[c] = nx * wt;
        total += w[c];
      end
      for (int c = 0; c < NCOLORS; c++)
        probs[s][c] = (total == 0) ? 17'(scaled_quotient(1, 5))
                                   : 17'(scaled_quotient(w[c], total));
      best = 0;
      for (int c = 1; c < NCOLORS; c++) if (probs[s][c] > probs[s][best]) best = c;
      cur = (probs[s][best] < 17'(threshold)) ? COLOR_UNKNOWN : 3'(best);
      if (cur == COLOR_GREEN) begin
        bright_ms[s] = t;
        stamps[s][0] = 1'b1;
      end else if (cur == COLOR_BLACK || cur == COLOR_UNKNOWN) begin
        dark_ms[s] = t;
        stamps[s][1] = 1'b1;
      end
      d = t - dark_ms[s];
      if (d[31]) d = 0 - d;
      if (cur == COLOR_GREEN && stamps[s][1] && d < {16'd0, dark_window}) blink[s] = 1;
      else if (!stamps[s][0] || later_by(t, bright_ms[s], blink_hold)) blink[s] = 0;
      seen_ms[s] = t;
      used[s] = 1;
      v.color = cur;
      v.conf = (probs[s][cur] > 65535) ? 16'hFFFF : probs[s][cur][15:0];
      v.blink = blink[s];
      pending = {pending, v};
    endfunction

    function void check_word(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        $display("%0t: expected no word, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.color !== want.color) begin
        $display("%0t: colour expected %0d actual %0d", $time, want.color, got.color);
        errors++;
      end
      if (got.conf !== want.conf) begin
        $display("%0t: conf expected %0d actual %0d", $time, want.conf, got.conf);
        errors++;
      end
      if (got.blink !== want.blink) begin
        $display("%0t: blink expected %0d actual %0d", $time, want.blink, got.blink);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  dbcf_obs_if obs();
  dbcf_res_if res();
  colour_scoreboard board = new();
  logic [31:0] clock_ms [16];
  int cycles = 0;
  bit stim_done = 0;

  discrete_bayes_color_filter_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .obs(obs.sink), .res(res.source)
  );

  always #6 clk = ~clk;

  initial begin
    obs.valid = 0;
    obs.slot = 0;
    obs.time_ms = 0;
    obs.seen_color = 0;
    obs.seen_conf = 0;
    res.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb_discrete_bayes_color_filter_top: errors");
      $finish;
    end
  end

  initial begin
    int gap;
    @(posedge clk);
    while (1) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        res.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      res.ready <= 1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
      board.check_word({res.out_color, res.out_conf, res.blinking});
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic send_word(logic [3:0] s, logic [31:0] t, logic [2:0] c, logic [15:0] f,
                           bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      obs.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    obs.valid <= 1;
    obs.slot <= s;
    obs.time_ms <= t;
    obs.seen_color <= c;
    obs.seen_conf <= f;
    @(posedge clk);
    while (!obs.ready) @(posedge clk);
    board.note_observation(s, t, c, f);
  endtask

  task automatic drain();
    obs.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    logic [3:0] s;
    logic [31:0] step;
    logic [2:0] c;
    logic [15:0] f;
    bit burst;
    for (int i = 0; i < count; i++) begin
      s = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
        0: step = $urandom;
        1: step = 32'hFFFF_FF00 + $urandom_range(0, 255);
        2: step = $urandom_range(1500, 7000);
        default: step = $urandom_range(0, 700);
      endcase
      clock_ms[s] = clock_ms[s] + step;
      c = $urandom_range(0, 9) == 0 ? 3'($urandom) :
          ($urandom_range(0, 2) == 0 ? COLOR_BLACK : 3'($urandom_range(1, 4)));
      f = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(40000, 65535));
      burst = (i / 40) % 3 == 0;
      send_word(s, clock_ms[s], c, f, burst);
    end
  endtask

  initial begin
    for (int s = 0; s < 16; s++) clock_ms[s] = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_word(0, 0, COLOR_RED, 16'hFFFF, 0);
    send_word(0, 100, COLOR_RED, 16'h0000, 0);
    send_word(0, 200, COLOR_UNKNOWN, 16'h8000, 0);
    send_word(0, 300, 3'd7, 16'h1234, 0);
    send_word(0, 400, 3'd5, 16'h1234, 0);
    send_word(1, 0, COLOR_BLACK, 16'hFFFF, 0);
    send_word(1, 200, COLOR_GREEN, 16'hFFFF, 0);
    send_word(1, 300, COLOR_GREEN, 16'hFFFF, 0);
    send_word(1, 400, COLOR_BLACK, 16'hFFFF, 0);
    send_word(1, 500, COLOR_GREEN, 16'hFFFF, 0);
    send_word(1, 2800, COLOR_YELLOW, 16'hFFFF, 0);
    send_word(1, 2700, COLOR_YELLOW, 16'hFFFF, 0);
    send_word(1, 9000, COLOR_GREEN, 16'hFFFF, 0);
    send_word(15, 32'hFFFF_FFFF, COLOR_GREEN, 16'h5555, 0);
    send_word(15, 32'h8000_0000, COLOR_GREEN, 16'hAAAA, 0);
    send_word(15, 32'h0000_0010, COLOR_RED, 16'h1999, 0);
    random_phase(150);
    drain();
    write_reg(REG_RESET_GAP, 0);
    write_reg(REG_CLEANUP_GAP, 16'hFFFF);
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_DARK_WINDOW, 16'hFFFF);
    write_reg(REG_BLINK_HOLD, 0);
    random_phase(120);
    drain();
    write_reg(REG_RESET_GAP, 16'hFFFF);
    write_reg(REG_CLEANUP_GAP, 0);
    write_reg(REG_THRESHOLD, 16'hFFFF);
    write_reg(REG_DARK_WINDOW, 0);
    write_reg(REG_BLINK_HOLD, 16'hFFFF);
    random_phase(100);
    drain();
    write_reg(REG_RESET_GAP, 16'($urandom_range(500, 3000)));
    write_reg(REG_CLEANUP_GAP, 16'($urandom_range(3000, 9000)));
    write_reg(REG_THRESHOLD, 16'($urandom));
    write_reg(REG_DARK_WINDOW, 16'($urandom_range(100, 1500)));
    write_reg(REG_BLINK_HOLD, 16'($urandom_range(200, 3000)));
    random_phase(130);
    drain();
    if (board.errors == 0) $display("tb_discrete_bayes_color_filter_top: clean");
    else $display("tb_discrete_bayes_color_filter_top: errors");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/dbcf_pkg.sv
rtl/dbcf_if.sv
rtl/dbcf_ram.sv
rtl/dbcf_div.sv
rtl/discrete_bayes_color_filter_top.sv
sim/tb_discrete_bayes_color_filter_top.sv
